/* rtl/signed_vector_angle_macros.svh */
// ----------------------------------------------------------------------------
// Signed vector angle: assertion macros
// Implication checks that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_VECTOR_ANGLE_MACROS_SVH
`define SIGNED_VECTOR_ANGLE_MACROS_SVH
`ifndef SYNTH
`define SVANG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svang: same-cycle check failed");
`define SVANG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svang: next-cycle check failed");
`else
`define SVANG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SVANG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/svang_pkg.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: package
// Widths, constants, arctangent table and inter-stage payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svang_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS   = 14;

    localparam int PROD_W      = 2 * COMPONENT_BITS;
    localparam int CROSS_W     = 2 * COMPONENT_BITS + 1;
    localparam int DOT_W       = 2 * COMPONENT_BITS + 2;
    localparam int MAG_W       = 2 * COMPONENT_BITS;
    localparam int SQ_W        = 4 * COMPONENT_BITS;
    localparam int ROOT_W      = 2 * COMPONENT_BITS;
    localparam int SQRT_STAGES = ROOT_W / 2;
    localparam int XY_W        = 2 * COMPONENT_BITS + 4;
    localparam int Z_W         = 24;
    localparam int ANGLE_W     = 15;
    localparam int FRAC_SHIFT  = 8;

    localparam logic signed [Z_W-1:0] PI_Q20    = Z_W'(3294199);
    localparam logic signed [Z_W-1:0] ROUND_Q20 = Z_W'(1 << (FRAC_SHIFT - 1));

    // atan(2^-i), Q3.20
    function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(823550);
            1:       v = Z_W'(486170);
            2:       v = Z_W'(256879);
            3:       v = Z_W'(130396);
            4:       v = Z_W'(65451);
            5:       v = Z_W'(32757);
            6:       v = Z_W'(16383);
            7:       v = Z_W'(8192);
            8:       v = Z_W'(4096);
            9:       v = Z_W'(2048);
            10:      v = Z_W'(1024);
            11:      v = Z_W'(512);
            12:      v = Z_W'(256);
            13:      v = Z_W'(128);
            14:      v = Z_W'(64);
            15:      v = Z_W'(32);
            16:      v = Z_W'(16);
            17:      v = Z_W'(8);
            18:      v = Z_W'(4);
            19:      v = Z_W'(2);
            20:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    cy_pos;
        logic [SQ_W-1:0]         sq;
    } t_geom;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    cy_pos;
        logic [ROOT_W-1:0]       mag;
    } t_polar;

endpackage

/* rtl/svang_if.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: channel interfaces
// Vector pair input channel and angle output channel, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface svang_vec_if import svang_pkg::*; ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] first_x;
    logic signed [COMPONENT_BITS-1:0] first_y;
    logic signed [COMPONENT_BITS-1:0] first_z;
    logic signed [COMPONENT_BITS-1:0] second_x;
    logic signed [COMPONENT_BITS-1:0] second_y;
    logic signed [COMPONENT_BITS-1:0] second_z;

    modport source (output valid, first_x, first_y, first_z,
                    second_x, second_y, second_z, input ready);
    modport sink   (input valid, first_x, first_y, first_z,
                    second_x, second_y, second_z, output ready);
endinterface

interface svang_angle_if import svang_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, angle, input ready);
    modport sink   (input valid, angle, output ready);
endinterface

/* rtl/svang_front.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: product front end
// Four stages: products, cross and dot sums, squares, sum of squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_vector_angle_macros.svh"

module svang_front import svang_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_ax,
    input  logic signed [COMPONENT_BITS-1:0] i_ay,
    input  logic signed [COMPONENT_BITS-1:0] i_az,
    input  logic signed [COMPONENT_BITS-1:0] i_bx,
    input  logic signed [COMPONENT_BITS-1:0] i_by,
    input  logic signed [COMPONENT_BITS-1:0] i_bz,
    output logic                             o_valid,
    input  logic                             i_ready,
    output t_geom                            o_geom
);

    localparam int NS = 4;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [PROD_W-1:0]  r_p_aybz, r_p_azby, r_p_azbx, r_p_axbz, r_p_axby, r_p_aybx;
    logic signed [PROD_W-1:0]  r_p_axbx, r_p_ayby, r_p_azbz;
    logic [MAG_W-1:0]          r_mx, r_my, r_mz;
    logic signed [DOT_W-1:0]   r_dot1, r_dot2, r_dot3;
    logic                      r_cy1, r_cy2, r_cy3;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz, r_sum;

    logic signed [CROSS_W-1:0] n_cx, n_cy, n_cz, n_ax, n_ay, n_az;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p_aybz <= PROD_W'(i_ay) * PROD_W'(i_bz);
            r_p_azby <= PROD_W'(i_az) * PROD_W'(i_by);
            r_p_azbx <= PROD_W'(i_az) * PROD_W'(i_bx);
            r_p_axbz <= PROD_W'(i_ax) * PROD_W'(i_bz);
            r_p_axby <= PROD_W'(i_ax) * PROD_W'(i_by);
            r_p_aybx <= PROD_W'(i_ay) * PROD_W'(i_bx);
            r_p_axbx <= PROD_W'(i_ax) * PROD_W'(i_bx);
            r_p_ayby <= PROD_W'(i_ay) * PROD_W'(i_by);
            r_p_azbz <= PROD_W'(i_az) * PROD_W'(i_bz);
        end
    end

    always_comb begin
        n_cx = CROSS_W'(r_p_aybz) - CROSS_W'(r_p_azby);
        n_cy = CROSS_W'(r_p_azbx) - CROSS_W'(r_p_axbz);
        n_cz = CROSS_W'(r_p_axby) - CROSS_W'(r_p_aybx);
        n_ax = (n_cx < 0) ? -n_cx : n_cx;
        n_ay = (n_cy < 0) ? -n_cy : n_cy;
        n_az = (n_cz < 0) ? -n_cz : n_cz;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_mx   <= n_ax[MAG_W-1:0];
            r_my   <= n_ay[MAG_W-1:0];
            r_mz   <= n_az[MAG_W-1:0];
            r_cy1  <= (n_cy > 0);
            r_dot1 <= DOT_W'(r_p_axbx) + DOT_W'(r_p_ayby) + DOT_W'(r_p_azbz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_sx   <= SQ_W'(r_mx) * SQ_W'(r_mx);
            r_sy   <= SQ_W'(r_my) * SQ_W'(r_my);
            r_sz   <= SQ_W'(r_mz) * SQ_W'(r_mz);
            r_cy2  <= r_cy1;
            r_dot2 <= r_dot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_sum  <= r_sx + r_sy + r_sz;
            r_cy3  <= r_cy2;
            r_dot3 <= r_dot2;
        end
    end

    assign o_ready       = en[0];
    assign o_valid       = r_vld[NS-1];
    assign o_geom.dot    = r_dot3;
    assign o_geom.cy_pos = r_cy3;
    assign o_geom.sq     = r_sum;

    `SVANG_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])

endmodule

/* rtl/svang_sqrt.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: pipelined integer square root
// Two result bits per stage, restoring, floor of the root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svang_sqrt import svang_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_geom  i_geom,
    output logic   o_valid,
    input  logic   i_ready,
    output t_polar o_polar
);

    localparam int NS = SQRT_STAGES;

    logic [NS-1:0]           r_vld;
    logic [NS-1:0]           en;
    logic [SQ_W:0]           r_v   [NS];
    logic [SQ_W:0]           r_r   [NS];
    logic signed [DOT_W-1:0] r_dot [NS];
    logic                    r_cy  [NS];

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dot[0] <= i_geom.dot;
            r_cy[0]  <= i_geom.cy_pos;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_dot[k] <= r_dot[k-1];
                r_cy[k]  <= r_cy[k-1];
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [SQ_W:0] w_v;
        logic [SQ_W:0] w_r;
        logic [SQ_W:0] n_v;
        logic [SQ_W:0] n_r;

        if (s == 0) begin : g_first
            assign w_v = (SQ_W + 1)'(i_geom.sq);
            assign w_r = '0;
        end else begin : g_next
            assign w_v = r_v[s-1];
            assign w_r = r_r[s-1];
        end

        always_comb begin
            logic [SQ_W:0] b;
            n_v = w_v;
            n_r = w_r;
            for (int j = 0; j < 2; j++) begin
                b = (SQ_W + 1)'(1) << (2 * (ROOT_W - 1 - 2 * s - j));
                if (n_v >= n_r + b) begin
                    n_v = n_v - (n_r + b);
                    n_r = (n_r >> 1) + b;
                end else begin
                    n_r = n_r >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_v[s] <= n_v;
                r_r[s] <= n_r;
            end
        end
    end

    assign o_ready        = en[0];
    assign o_valid        = r_vld[NS-1];
    assign o_polar.dot    = r_dot[NS-1];
    assign o_polar.cy_pos = r_cy[NS-1];
    assign o_polar.mag    = r_r[NS-1][ROOT_W-1:0];

endmodule

/* rtl/svang_cordic.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: vectoring CORDIC and output stage
// One rotation per stage, then quadrant fix and clamp, then rounding and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_vector_angle_macros.svh"

module svang_cordic import svang_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_polar                    i_polar,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ANGLE_W-1:0] o_angle
);

    localparam int CS = CORDIC_STEPS;
    localparam int NS = CORDIC_STEPS + 2;

    logic [NS-1:0]            r_vld;
    logic [NS-1:0]            en;
    logic signed [XY_W-1:0]   r_x    [CS];
    logic signed [XY_W-1:0]   r_y    [CS];
    logic signed [Z_W-1:0]    r_z    [CS];
    logic                     r_neg  [CS];
    logic                     r_zero [CS];
    logic                     r_cy   [NS];
    logic signed [Z_W-1:0]    r_zc;
    logic signed [ANGLE_W-1:0] r_angle;

    logic signed [XY_W-1:0]   w_dext;
    logic signed [Z_W-1:0]    n_zq;
    logic signed [Z_W-1:0]    n_zc;
    logic signed [Z_W-1:0]    n_rnd;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_neg[0]  <= (i_polar.dot < 0);
            r_zero[0] <= (i_polar.mag == '0);
            r_cy[0]   <= i_polar.cy_pos;
        end
        for (int k = 1; k < CS; k++) begin
            if (en[k]) begin
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_cy[k]   <= r_cy[k-1];
            end
        end
    end

    assign w_dext = XY_W'(i_polar.dot);

    for (genvar i = 0; i < CS; i++) begin : g_iter
        logic signed [XY_W-1:0] w_x, w_y, n_x, n_y;
        logic signed [Z_W-1:0]  w_z, n_z;

        if (i == 0) begin : g_first
            assign w_x = (w_dext < 0) ? -w_dext : w_dext;
            assign w_y = XY_W'(i_polar.mag);
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end

        always_comb begin
            if (w_y > 0) begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + atan_q20(i);
            end else begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - atan_q20(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[i]) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    // quadrant fix and clamp to [0, pi]; 0 or pi when the cross product is zero
    always_comb begin
        n_zq = r_neg[CS-1] ? (PI_Q20 - r_z[CS-1]) : r_z[CS-1];
        if (r_zero[CS-1]) begin
            n_zc = r_neg[CS-1] ? PI_Q20 : '0;
        end else if (n_zq < 0) begin
            n_zc = '0;
        end else if (n_zq > PI_Q20) begin
            n_zc = PI_Q20;
        end else begin
            n_zc = n_zq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[CS]) begin
            r_zc <= n_zc;
        end
    end

    assign n_rnd = (r_zc + ROUND_Q20) >>> FRAC_SHIFT;

    always_ff @(posedge i_clk) begin
        if (en[CS+1]) begin
            r_angle <= r_cy[CS] ? -n_rnd[ANGLE_W-1:0] : n_rnd[ANGLE_W-1:0];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_angle = r_angle;

    `SVANG_ASSERT_IMP(a_angle_range, i_clk, i_rst_n, o_valid, (r_angle <= 15'sd12868) && (r_angle >= -15'sd12868))
    `SVANG_ASSERT_IMP(a_angle_sign, i_clk, i_rst_n, o_valid && r_cy[NS-1], r_angle <= 0)
    `SVANG_ASSERT_IMP(a_clamp_range, i_clk, i_rst_n, r_vld[CS], (r_zc >= 0) && (r_zc <= PI_Q20))

endmodule

/* rtl/signed_vector_angle.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: top level
// Signed angle between two 3D Q4.12 vectors, output in Q3.12 radians.
// ----------------------------------------------------------------------------
// Input channel i_in carries one vector pair per beat, output channel o_out
// one angle per beat; both are valid/ready, a beat moves when both are high.
// The angle is atan2(|a x b|, a . b) in [0, pi], negated when the y part of
// the cross product is positive; parallel or zero vectors give 0 or pi.
// The pipeline has 4 product stages, 16 square-root stages (two root bits
// each), 14 CORDIC rotation stages and 2 output stages. A new pair is taken
// every cycle unless a stall on o_out has backed up to i_in.
// Each stage holds its own valid bit and loads when it is empty or when the
// stage after it can move, so a receiver stall fills empty stages first and
// then pushes back to i_in.ready; nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_vector_angle import svang_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    svang_vec_if.sink            i_in,
    svang_angle_if.source        o_out
);

    logic   front_valid, front_ready;
    logic   sqrt_valid, sqrt_ready;
    t_geom  front_geom;
    t_polar sqrt_polar;

    svang_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_ax    (i_in.first_x),
        .i_ay    (i_in.first_y),
        .i_az    (i_in.first_z),
        .i_bx    (i_in.second_x),
        .i_by    (i_in.second_y),
        .i_bz    (i_in.second_z),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_geom  (front_geom)
    );

    svang_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_geom  (front_geom),
        .o_valid (sqrt_valid),
        .i_ready (sqrt_ready),
        .o_polar (sqrt_polar)
    );

    svang_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .o_ready (sqrt_ready),
        .i_polar (sqrt_polar),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_angle (o_out.angle)
    );

endmodule

/* bench/signed_vector_angle_tb.sv */
// ----------------------------------------------------------------------------
// Signed vector angle: testbench
// Drives vector pairs with random gaps, stalls the angle output at random
// and checks every angle against a bit-accurate CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_vector_angle_tb import svang_pkg::*; ();

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;

    typedef struct {
        t_comp ax, ay, az, bx, by, bz;
        logic  known;
        logic signed [ANGLE_W-1:0] angle;
    } t_row;

    localparam int N_RANDOM = 1000;
    localparam int N_ROWS   = 14;
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 15'sd12868;
    localparam t_comp CMAX = 16'sh7fff;
    localparam t_comp CMIN = 16'sh8000;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;

    logic signed [ANGLE_W-1:0] angle_q[$];

    svang_vec_if   vec_if ();
    svang_angle_if ang_if ();

    signed_vector_angle u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vec_if.sink),
        .o_out   (ang_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] predict_angle(
        input t_comp ax, ay, az, bx, by, bz);
        longint cx, cy, cz, d, m, x, y, z, xs, ys, ang;
        longint ux, uy, uz;
        cx = longint'(ay) * bz - longint'(az) * by;
        cy = longint'(az) * bx - longint'(ax) * bz;
        cz = longint'(ax) * by - longint'(ay) * bx;
        d  = longint'(ax) * bx + longint'(ay) * by + longint'(az) * bz;
        ux = cx < 0 ? -cx : cx;
        uy = cy < 0 ? -cy : cy;
        uz = cz < 0 ? -cz : cz;
        m  = isqrt(ux * ux + uy * uy + uz * uz);
        z  = 0;
        if (m == 0) begin
            z = (d < 0) ? longint'(PI_Q20) : 0;
        end else begin
            x = d < 0 ? -d : d;
            y = m;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += longint'(atan_q20(i));
                end else begin
                    x -= ys; y += xs; z -= longint'(atan_q20(i));
                end
            end
            if (d < 0) z = longint'(PI_Q20) - z;
            if (z < 0) z = 0;
            if (z > longint'(PI_Q20)) z = longint'(PI_Q20);
        end
        ang = (z + 128) >>> 8;
        if (cy > 0) ang = -ang;
        return ang[ANGLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb: mismatch %s", what);
        n_errors++;
    endtask

    task automatic send_pair(input t_row r);
        int gap;
        logic signed [ANGLE_W-1:0] want;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        want = predict_angle(r.ax, r.ay, r.az, r.bx, r.by, r.bz);
        if (r.known && want !== r.angle)
            report_mismatch($sformatf("predictor %0d vs table %0d", want, r.angle));
        vec_if.valid    <= 1'b1;
        vec_if.first_x  <= r.ax;
        vec_if.first_y  <= r.ay;
        vec_if.first_z  <= r.az;
        vec_if.second_x <= r.bx;
        vec_if.second_y <= r.by;
        vec_if.second_z <= r.bz;
        do @(posedge i_clk); while (!vec_if.ready);
        angle_q = {angle_q, (r.known ? r.angle : want)};
        @(negedge i_clk);
    endtask

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return t_comp'(int'($urandom_range(0, 15)) - 8);
            default: return t_comp'($urandom);
        endcase
    endfunction

    // output side: random stalls, check each beat
    initial begin
        int stall;
        ang_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                ang_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            ang_if.ready <= 1'b1;
            do @(posedge i_clk); while (!ang_if.valid);
            if (angle_q.size() == 0)
                report_mismatch("angle beat with nothing expected");
            else if (ang_if.angle !== angle_q[0]) begin
                report_mismatch($sformatf("angle %0d, expected %0d",
                    ang_if.angle, angle_q[0]));
                void'(angle_q.pop_front());
            end else
                void'(angle_q.pop_front());
        end
    end

    initial begin
        t_row rows [N_ROWS];
        t_row r;
        n_errors = 0;
        vec_if.valid = 1'b0;
        vec_if.first_x = '0; vec_if.first_y = '0; vec_if.first_z = '0;
        vec_if.second_x = '0; vec_if.second_y = '0; vec_if.second_z = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows[0]  = '{0, 0, 0, 0, 0, 0, 1'b1, 15'sd0};
        rows[1]  = '{CMAX, 0, 0, CMAX, 0, 0, 1'b1, 15'sd0};
        rows[2]  = '{CMAX, 0, 0, CMIN, 0, 0, 1'b1, ANGLE_PI};
        rows[3]  = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1, 15'sd0};
        rows[4]  = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0, 15'sd0};
        rows[5]  = '{16'sd4096, 0, 0, 0, 16'sd4096, 0, 1'b0, 15'sd0};
        rows[6]  = '{16'sd4096, 0, 0, 0, 0, 16'sd4096, 1'b0, 15'sd0};
        rows[7]  = '{0, 0, 16'sd4096, 16'sd4096, 0, 0, 1'b0, 15'sd0};
        rows[8]  = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1'b0, 15'sd0};
        rows[9]  = '{CMAX, CMIN, 0, 0, CMAX, CMIN, 1'b0, 15'sd0};
        rows[10] = '{16'sd1, 0, 0, 16'sd1, 16'sd1, 0, 1'b0, 15'sd0};
        rows[11] = '{16'sd1, 0, 0, -16'sd1, 16'sd1, 0, 1'b0, 15'sd0};
        rows[12] = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, 15'sd0};
        rows[13] = '{16'sd3, 16'sd5, 0, 0, 0, 0, 1'b1, 15'sd0};
        foreach (rows[i]) send_pair(rows[i]);

        repeat (N_RANDOM) begin
            r.ax = rand_comp(); r.ay = rand_comp(); r.az = rand_comp();
            if ($urandom_range(0, 7) == 0) begin
                // parallel or antiparallel
                r.bx = ($urandom_range(0, 1) ? r.ax : -r.ax);
                r.by = r.bx == r.ax ? r.ay : -r.ay;
                r.bz = r.bx == r.ax ? r.az : -r.az;
            end else begin
                r.bx = rand_comp(); r.by = rand_comp(); r.bz = rand_comp();
            end
            r.known = 1'b0;
            r.angle = '0;
            send_pair(r);
        end
        vec_if.valid <= 1'b0;

        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
